// ===== rtl/gbfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

  // payload store depth and address width
  localparam int MaxPayload = 255;
  localparam int StoreAw    = $clog2(MaxPayload);

  // item kinds
  typedef enum logic [1:0] {
    KindByte    = 2'd0,
    KindRelease = 2'd1,
    KindRead    = 2'd2,
    KindNop     = 2'd3
  } kind_e;

  // event codes on the result channel
  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvDone     = 3'd1,
    EvSync     = 3'd2,
    EvLength   = 3'd3,
    EvChecksum = 3'd4,
    EvOverrun  = 3'd5
  } event_e;

  // configuration register indexes
  typedef enum logic {
    CfgSyncFirst  = 1'b0,
    CfgSyncSecond = 1'b1
  } cfg_index_e;

  localparam logic [7:0] SyncFirstReset  = 8'd181;
  localparam logic [7:0] SyncSecondReset = 8'd98;

  localparam logic [15:0] CountMax = 16'hFFFF;

  // one input item as held in the input register
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } item_t;

  // one result item
  typedef struct packed {
    event_e      event_res;
    logic        frame_held;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [7:0]  msg_length;
    logic [7:0]  read_data;
    logic [15:0] error_count;
    logic [15:0] overrun_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/gbfp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gbfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] read_index;

  modport source (output valid, output kind, output data_byte, output read_index,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input read_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/gbfp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gbfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        frame_held;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [7:0]  msg_length;
  logic [7:0]  read_data;
  logic [15:0] error_count;
  logic [15:0] overrun_count;

  modport source (output valid, output event_res, output frame_held, output msg_class,
                  output msg_id, output msg_length, output read_data,
                  output error_count, output overrun_count, input ready);
  modport sink   (input valid, input event_res, input frame_held, input msg_class,
                  input msg_id, input msg_length, input read_data,
                  input error_count, input overrun_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/gbfp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbfp_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  gbfp_in_if.sink              in_i,
  input  wire logic            advance_i,
  output gbfp_pkg::item_t      item_o,
  output logic                 valid_o
);

  logic            valid_q, valid_d;
  gbfp_pkg::item_t item_q;

  // slot is free when empty or when its item moves on this cycle
  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.valid && in_i.ready) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.kind       <= gbfp_pkg::kind_e'(in_i.kind);
      item_q.data_byte  <= in_i.data_byte;
      item_q.read_index <= in_i.read_index;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/gbfp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbfp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      sync_first_i,
  input  wire logic [7:0]      sync_second_i,
  input  wire logic            advance_i,
  input  wire gbfp_pkg::item_t item_i,
  output gbfp_pkg::result_t    result_o
);

  typedef enum logic [3:0] {
    PhWait1 = 4'd0,
    PhSync1 = 4'd1,
    PhClass = 4'd2,
    PhId    = 4'd3,
    PhLenLo = 4'd4,
    PhLenHi = 4'd5,
    PhData  = 4'd6,
    PhCkA   = 4'd7,
    PhCkB   = 4'd8
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       sum_a_q, sum_a_d;
  logic [7:0]       sum_b_q, sum_b_d;
  logic [7:0]       class_q, class_d;
  logic [7:0]       id_q, id_d;
  logic [15:0]      length_q, length_d;
  logic [7:0]       pos_q, pos_d;
  logic             held_q, held_d;
  logic [15:0]      err_q, err_d;
  logic [15:0]      ovr_q, ovr_d;
  gbfp_pkg::event_e event_q, event_d;

  logic [7:0]       store_mem [gbfp_pkg::MaxPayload];
  logic             store_we;
  logic [7:0]       read_q;
  logic             read_en;

  logic [7:0]       c;
  logic [7:0]       sum_a_add;
  logic [7:0]       sum_b_add;
  logic [15:0]      length_full;
  logic [7:0]       pos_next;
  logic             count_err;

  assign c           = item_i.data_byte;
  assign sum_a_add   = sum_a_q + c;
  assign sum_b_add   = sum_b_q + sum_a_add;
  assign length_full = {c, length_q[7:0]};
  assign pos_next    = pos_q + 8'd1;

  // next state for one item
  always_comb begin
    phase_d   = phase_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    class_d   = class_q;
    id_d      = id_q;
    length_d  = length_q;
    pos_d     = pos_q;
    held_d    = held_q;
    ovr_d     = ovr_q;
    event_d   = gbfp_pkg::EvNone;
    count_err = 1'b0;
    store_we  = 1'b0;

    if (advance_i) begin
      case (item_i.kind)
        gbfp_pkg::KindByte: begin
          // running checksum over class through payload
          if (phase_q == PhClass || phase_q == PhId || phase_q == PhLenLo ||
              phase_q == PhLenHi || phase_q == PhData) begin
            sum_a_d = sum_a_add;
            sum_b_d = sum_b_add;
          end
          unique case (phase_q)
            PhSync1: begin
              if (c != sync_second_i) begin
                count_err = 1'b1;
                event_d   = gbfp_pkg::EvSync;
                phase_d   = PhWait1;
              end else begin
                sum_a_d = 8'd0;
                sum_b_d = 8'd0;
                phase_d = PhClass;
              end
            end
            PhClass: begin
              if (held_q) begin
                if (ovr_q != gbfp_pkg::CountMax) begin
                  ovr_d = ovr_q + 16'd1;
                end
                event_d = gbfp_pkg::EvOverrun;
                phase_d = PhWait1;
              end else begin
                class_d = c;
                phase_d = PhId;
              end
            end
            PhId: begin
              id_d    = c;
              phase_d = PhLenLo;
            end
            PhLenLo: begin
              length_d = {8'd0, c};
              phase_d  = PhLenHi;
            end
            PhLenHi: begin
              length_d = length_full;
              if (length_full > 16'(gbfp_pkg::MaxPayload)) begin
                count_err = 1'b1;
                event_d   = gbfp_pkg::EvLength;
                phase_d   = PhWait1;
              end else begin
                pos_d   = 8'd0;
                phase_d = (length_full == 16'd0) ? PhCkA : PhData;
              end
            end
            PhData: begin
              store_we = ({8'd0, pos_q} < 16'(gbfp_pkg::MaxPayload));
              pos_d    = pos_next;
              if ({8'd0, pos_next} >= length_q) begin
                phase_d = PhCkA;
              end
            end
            PhCkA: begin
              if (c != sum_a_q) begin
                count_err = 1'b1;
                event_d   = gbfp_pkg::EvChecksum;
                phase_d   = PhWait1;
              end else begin
                phase_d = PhCkB;
              end
            end
            PhCkB: begin
              if (c != sum_b_q) begin
                count_err = 1'b1;
                event_d   = gbfp_pkg::EvChecksum;
              end else begin
                held_d  = 1'b1;
                event_d = gbfp_pkg::EvDone;
              end
              phase_d = PhWait1;
            end
            default: begin
              phase_d = (c == sync_first_i) ? PhSync1 : PhWait1;
            end
          endcase
        end
        gbfp_pkg::KindRelease: begin
          held_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // saturating error count
  always_comb begin
    err_d = err_q;
    if (count_err && err_q != gbfp_pkg::CountMax) begin
      err_d = err_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait1;
      sum_a_q  <= 8'd0;
      sum_b_q  <= 8'd0;
      class_q  <= 8'd0;
      id_q     <= 8'd0;
      length_q <= 16'd0;
      pos_q    <= 8'd0;
      held_q   <= 1'b0;
      err_q    <= 16'd0;
      ovr_q    <= 16'd0;
      event_q  <= gbfp_pkg::EvNone;
    end else begin
      phase_q  <= phase_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
      class_q  <= class_d;
      id_q     <= id_d;
      length_q <= length_d;
      pos_q    <= pos_d;
      held_q   <= held_d;
      err_q    <= err_d;
      ovr_q    <= ovr_d;
      if (advance_i) begin
        event_q <= event_d;
      end
    end
  end

  // payload store write
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[pos_q[gbfp_pkg::StoreAw-1:0]] <= c;
    end
  end

  // payload store read, registered with the result
  assign read_en = (item_i.kind == gbfp_pkg::KindRead) &&
                   ({8'd0, item_i.read_index} < 16'(gbfp_pkg::MaxPayload));

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      if (read_en) begin
        read_q <= store_mem[item_i.read_index[gbfp_pkg::StoreAw-1:0]];
      end else begin
        read_q <= 8'd0;
      end
    end
  end

  // result fields follow the state left by the last item
  always_comb begin
    result_o.event_res     = event_q;
    result_o.frame_held    = held_q;
    result_o.msg_class     = class_q;
    result_o.msg_id        = id_q;
    result_o.msg_length    = (length_q > 16'd255) ? 8'd255 : length_q[7:0];
    result_o.read_data     = read_q;
    result_o.error_count   = err_q;
    result_o.overrun_count = ovr_q;
  end

endmodule

`default_nettype wire

// ===== rtl/gnss_binary_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a result is registered in the result register after its item moves on from the input register
// throughput: one item per cycle while the result is not stalled, set by the per-byte parse step
//   between the input register and the result register
// reset: parser idle waiting for first sync, counters and header cleared,
//   sync values 181 and 98; the payload store is not cleared

module gnss_binary_frame_parser_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  gbfp_in_if.sink         in_i,
  gbfp_out_if.source      out_o
);

  logic              out_valid_q, out_valid_d;
  logic              s1_valid;
  logic              advance;
  logic [7:0]        sync_first_q;
  logic [7:0]        sync_second_q;
  gbfp_pkg::item_t   s1_item;
  gbfp_pkg::result_t result;

  // item moves into the result slot when that slot is free or being emptied
  assign advance = s1_valid && (!out_valid_q || out_o.ready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= gbfp_pkg::SyncFirstReset;
      sync_second_q <= gbfp_pkg::SyncSecondReset;
    end else if (cfg_we_i) begin
      unique case (gbfp_pkg::cfg_index_e'(cfg_index_i))
        gbfp_pkg::CfgSyncFirst:  sync_first_q  <= cfg_data_i;
        gbfp_pkg::CfgSyncSecond: sync_second_q <= cfg_data_i;
      endcase
    end
  end

  gbfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (s1_item),
    .valid_o   (s1_valid)
  );

  gbfp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .advance_i     (advance),
    .item_i        (s1_item),
    .result_o      (result)
  );

  // result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_res     = result.event_res;
  assign out_o.frame_held    = result.frame_held;
  assign out_o.msg_class     = result.msg_class;
  assign out_o.msg_id        = result.msg_id;
  assign out_o.msg_length    = result.msg_length;
  assign out_o.read_data     = result.read_data;
  assign out_o.error_count   = result.error_count;
  assign out_o.overrun_count = result.overrun_count;

endmodule

`default_nettype wire

// ===== rtl/gbfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_res,
  input wire logic        frame_held,
  input wire logic [15:0] error_count,
  input wire logic [15:0] overrun_count
);

  // input only backs up when a result is stalled
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // a completed frame is held
  a_done_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && event_res == gbfp_pkg::EvDone) |-> frame_held)
    else $error("frame complete without held frame");

  // overrun only happens while a frame is held
  a_ovr_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && event_res == gbfp_pkg::EvOverrun) |-> (frame_held && overrun_count != 16'd0))
    else $error("overrun without held frame");

  // stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(event_res) && $stable(error_count) && $stable(frame_held)))
    else $error("stalled result changed");

endmodule

bind gnss_binary_frame_parser_core gbfp_checker u_gbfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .event_res     (out_o.event_res),
  .frame_held    (out_o.frame_held),
  .error_count   (out_o.error_count),
  .overrun_count (out_o.overrun_count)
);

`default_nettype wire
